FILE: design/marker_framed_packet_checker_assert.svh
// Assertion macros for the marker framed packet checker.
// Used by the port-level checker; no other dependencies.
`ifndef MARKER_FRAMED_PACKET_CHECKER_ASSERT_SVH
`define MARKER_FRAMED_PACKET_CHECKER_ASSERT_SVH

// Checked on every clock edge outside reset.
`define MFPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define MFPC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/mfpc_pkg.sv
// Shared types and constants for the marker framed packet checker.
// No dependencies.
package mfpc_pkg;

  localparam logic [7:0]  MARK_PREAMBLE = 8'hbe;
  localparam logic [7:0]  MARK_SYNC     = 8'haa;
  localparam logic [7:0]  MARK_TRAILER  = 8'h55;
  localparam logic [7:0]  MARK_TAIL     = 8'hed;
  localparam logic [7:0]  TYPE_DEVINFO  = 8'h01;
  localparam logic [15:0] MARK_COUNT    = 16'd8;

  typedef enum logic [2:0] {
    PH_PREAMBLE = 3'd0,
    PH_SYNC     = 3'd1,
    PH_HEADER   = 3'd2,
    PH_PAYLOAD  = 3'd3,
    PH_CHECK    = 3'd4,
    PH_TRAILER  = 3'd5,
    PH_TAIL     = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK_DEVINFO = 3'd0,
    ST_OK_OTHER   = 3'd1,
    ST_PREAMBLE   = 3'd2,
    ST_SYNC       = 3'd3,
    ST_CHECKSUM   = 3'd4,
    ST_TRAILER    = 3'd5,
    ST_TAIL       = 3'd6,
    ST_TRUNCATED  = 3'd7
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_of_datagram;
  } item_t;

  typedef struct packed {
    logic        has_result;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        verdict_valid;
    logic [2:0]  frame_status;
    logic [7:0]  frame_type;
    logic [15:0] payload_length;
  } result_t;

endpackage

FILE: design/mfpc_in_reg.sv
// Input register stage: holds one received byte until the parser consumes it.
// Depends on mfpc_pkg.
module mfpc_in_reg
  import mfpc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

FILE: design/mfpc_parser.sv
// Frame parser: phase state machine, byte counter, length/type capture and sum.
// Depends on mfpc_pkg.
module mfpc_parser
  import mfpc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    consume,
  input  item_t   item,
  output result_t res
);

  phase_t      phase_r, phase_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  type_r, type_nxt;
  logic        sent_r, sent_nxt;

  logic [15:0] pos_inc;
  logic [7:0]  mark;
  status_t     fail_code;
  phase_t      mark_next;
  logic        pv, vv;
  status_t     st;
  logic [7:0]  b;

  assign b       = item.data_byte;
  assign pos_inc = pos_r + 16'd1;

  // Marker byte, failure code and following phase for the four marker runs
  always_comb begin
    unique case (phase_r)
      PH_PREAMBLE: begin mark = MARK_PREAMBLE; fail_code = ST_PREAMBLE; mark_next = PH_SYNC;    end
      PH_SYNC:     begin mark = MARK_SYNC;     fail_code = ST_SYNC;     mark_next = PH_HEADER;  end
      PH_TRAILER:  begin mark = MARK_TRAILER;  fail_code = ST_TRAILER;  mark_next = PH_TAIL;    end
      default:     begin mark = MARK_TAIL;     fail_code = ST_TAIL;     mark_next = PH_TAIL;    end
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    type_nxt  = type_r;
    sent_nxt  = sent_r;
    pv        = 1'b0;
    vv        = 1'b0;
    st        = ST_OK_DEVINFO;

    if (!sent_r) begin
      unique case (phase_r) inside
        PH_PREAMBLE, PH_SYNC, PH_TRAILER, PH_TAIL: begin
          if (b != mark) begin
            vv = 1'b1;
            st = fail_code;
          end else if (pos_inc >= MARK_COUNT) begin
            pos_nxt   = '0;
            phase_nxt = mark_next;
            if (phase_r == PH_TAIL) begin
              vv = 1'b1;
              st = (type_r == TYPE_DEVINFO) ? ST_OK_DEVINFO : ST_OK_OTHER;
            end
          end else begin
            pos_nxt = pos_inc;
          end
        end
        PH_HEADER: begin
          if (pos_r == 16'd0) begin
            len_nxt = {8'h00, b};
            pos_nxt = 16'd1;
          end else if (pos_r == 16'd1) begin
            len_nxt = {b, len_r[7:0]};
            pos_nxt = 16'd2;
          end else begin
            type_nxt  = b;
            pos_nxt   = '0;
            sum_nxt   = '0;
            phase_nxt = (len_r != 16'd0) ? PH_PAYLOAD : PH_CHECK;
          end
        end
        PH_PAYLOAD: begin
          pv      = 1'b1;
          sum_nxt = sum_r + b;
          if (pos_inc >= len_r) begin
            pos_nxt   = '0;
            phase_nxt = PH_CHECK;
          end else begin
            pos_nxt = pos_inc;
          end
        end
        PH_CHECK: begin
          if (b != sum_r) begin
            vv = 1'b1;
            st = ST_CHECKSUM;
          end else begin
            pos_nxt   = '0;
            phase_nxt = PH_TRAILER;
          end
        end
        default: begin
          phase_nxt = PH_PREAMBLE;
        end
      endcase

      if (!vv && item.last_of_datagram) begin
        vv = 1'b1;
        st = ST_TRUNCATED;
      end
    end

    // verdict reports the captured fields as updated by this byte
    res.has_result     = pv || vv;
    res.payload_valid  = pv;
    res.payload_byte   = pv ? b : 8'h00;
    res.verdict_valid  = vv;
    res.frame_status   = vv ? st : ST_OK_DEVINFO;
    res.frame_type     = vv ? type_nxt : 8'h00;
    res.payload_length = vv ? len_nxt : 16'h0000;

    if (vv) begin
      sent_nxt = 1'b1;
    end
    if (item.last_of_datagram) begin
      phase_nxt = PH_PREAMBLE;
      pos_nxt   = '0;
      len_nxt   = '0;
      sum_nxt   = '0;
      type_nxt  = '0;
      sent_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PREAMBLE;
      pos_r   <= '0;
      len_r   <= '0;
      sum_r   <= '0;
      type_r  <= '0;
      sent_r  <= 1'b0;
    end else if (consume) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
      type_r  <= type_nxt;
      sent_r  <= sent_nxt;
    end
  end

endmodule

FILE: design/mfpc_out_reg.sv
// Result register: holds one result until the downstream side takes it.
// Depends on mfpc_pkg.
module mfpc_out_reg
  import mfpc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res,
  output logic    can_load,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

FILE: design/marker_framed_packet_checker.sv
// Marker framed packet checker: one datagram byte per transfer in, payload bytes
// and one verdict per datagram out. Bytes pass the input register, a combinational parser
// step and the result register. Throughput: one byte per cycle unless the result register
// is full and stalled; bytes that give no result are absorbed without output.
// Reset (rst_n low, synchronous): parser returns to the preamble phase, both stages empty.
// Depends on mfpc_pkg, mfpc_in_reg, mfpc_parser, mfpc_out_reg.
module marker_framed_packet_checker
  import mfpc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_of_datagram,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_payload_valid,
  output logic [7:0]  out_payload_byte,
  output logic        out_verdict_valid,
  output logic [2:0]  out_frame_status,
  output logic [7:0]  out_frame_type,
  output logic [15:0] out_payload_length
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    consume;
  logic    can_load;
  result_t res;
  result_t out_res;

  assign in_item.data_byte        = in_data_byte;
  assign in_item.last_of_datagram = in_last_of_datagram;

  // parser step happens whenever an item is held and the result register has room
  assign consume = item_valid && can_load;

  mfpc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (consume),
    .item_valid (item_valid),
    .item       (item)
  );

  mfpc_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .consume (consume),
    .item    (item),
    .res     (res)
  );

  mfpc_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (consume && res.has_result),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_payload_valid  = out_res.payload_valid;
  assign out_payload_byte   = out_res.payload_byte;
  assign out_verdict_valid  = out_res.verdict_valid;
  assign out_frame_status   = out_res.frame_status;
  assign out_frame_type     = out_res.frame_type;
  assign out_payload_length = out_res.payload_length;

endmodule

FILE: design/mfpc_checker.sv
// Port-level checker for the marker framed packet checker, bound to the top level.
// Depends on marker_framed_packet_checker_assert.svh.
`include "marker_framed_packet_checker_assert.svh"

module mfpc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_payload_valid,
  input logic [7:0]  out_payload_byte,
  input logic        out_verdict_valid,
  input logic [2:0]  out_frame_status,
  input logic [7:0]  out_frame_type,
  input logic [15:0] out_payload_length
);

  `MFPC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid right after reset")

  `MFPC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_payload_byte) && $stable(out_frame_status) && $stable(out_payload_length), "stalled result changed")

  `MFPC_ASSERT(a_nonempty, out_valid |-> out_payload_valid || out_verdict_valid, "result carries neither payload nor verdict")

  `MFPC_ASSERT(a_no_verdict_zero, out_valid && !out_verdict_valid |-> out_frame_status == 3'd0 && out_frame_type == 8'h00 && out_payload_length == 16'h0000, "verdict fields set without verdict")

  `MFPC_ASSERT(a_no_payload_zero, out_valid && !out_payload_valid |-> out_payload_byte == 8'h00, "payload byte set without payload")

endmodule

bind marker_framed_packet_checker mfpc_checker u_mfpc_checker (.*);
